/* sv/bmbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbt_pkg
// Shared types and constants for the block-map bus translator.
// ----------------------------------------------------------------------------
package bmbt_pkg;

  localparam int BUS_AW    = 32;
  localparam int BLK_SHIFT = 20;

  localparam int TBL_BITS = (BUS_AW > BLK_SHIFT) ? (BUS_AW - BLK_SHIFT) : 0;
  localparam int TBL_SIZE = 1 << TBL_BITS;
  localparam int IDX_W    = (TBL_BITS > 0) ? TBL_BITS : 1;
  localparam int LEN_W    = BLK_SHIFT + 1;

  localparam logic [IDX_W-1:0] IDX_MASK      = IDX_W'(TBL_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(TBL_SIZE - 1);
  localparam logic [31:0]      BUS_KEEP_MASK = 32'((64'd1 << BUS_AW) - 64'd1);
  localparam logic [31:0]      BLK_SIZE      = 32'(64'd1 << BLK_SHIFT);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_UNMAPPED  = 3'd1,
    STATUS_DENIED    = 3'd2,
    STATUS_BEYOND    = 3'd3,
    STATUS_ALREADY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [1:0]       prot;
    logic [LEN_W-1:0] length;
    logic [31:0]      base;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

/* sv/bmbt_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbt_table
// Block table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmbt_table (
  input  logic                           clk_i,
  input  bmbt_pkg::tbl_wr_t              wr_i,
  input  logic [bmbt_pkg::IDX_W-1:0]     raddr_i,
  output bmbt_pkg::entry_t               rdata_o
);

  bmbt_pkg::entry_t mem [bmbt_pkg::TBL_SIZE];
  bmbt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/block_map_bus_translator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_map_bus_translator_core
// Translates bus accesses through a table of fixed-size blocks and maps
// regions into that table after checking that every block is free.
// ----------------------------------------------------------------------------
// Read/write: the entry is read from the table in the accept cycle, checked in
//   ST_ACCESS, and done_o is registered; busy_o stays high until done_o strobes.
// Map: each block is scanned in ST_SCAN_RD and ST_SCAN_CHK, then filled in ST_WRITE.
// Operation code three and zero-length maps: done_o in the cycle after accept.
// Reset: a clearing pass writes all 4096 entries, one per cycle, with busy_o
//   high; the receiver cannot stall done_o.
// ----------------------------------------------------------------------------
module block_map_bus_translator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  size_code_i,
  input  logic [31:0] region_length_i,
  input  logic [1:0]  region_prot_i,
  input  logic [31:0] region_base_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] target_address_o
);

  localparam int IW = bmbt_pkg::IDX_W;
  localparam int LW = bmbt_pkg::LEN_W;
  localparam int BB = bmbt_pkg::BLK_SHIFT;

  bmbt_pkg::state_e  state_q, state_d;
  logic [IW-1:0]     blk_q, blk_d;
  logic [IW-1:0]     first_q, first_d;
  logic [IW-1:0]     last_q, last_d;
  logic [31:0]       addr_q, addr_d;
  logic [1:0]        op_q, op_d;
  logic [1:0]        size_q, size_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       base_q, base_d;
  logic [1:0]        prot_q, prot_d;
  logic              done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [31:0]       target_q, target_d;

  bmbt_pkg::tbl_wr_t wr;
  logic [IW-1:0]     raddr;
  bmbt_pkg::entry_t  rdata;

  logic              accept;
  logic [31:0]       addr_in;
  logic [32:0]       end_sum;
  logic [32:0]       end_blk;
  logic [IW-1:0]     last_in;
  logic [BB-1:0]     off;
  logic [LW-1:0]     need_end;
  logic              perm_ok;

  bmbt_table u_table (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign accept  = start_i && (state_q == bmbt_pkg::ST_IDLE);
  assign addr_in = address_i & bmbt_pkg::BUS_KEEP_MASK;
  assign end_sum = {1'b0, addr_in} + {1'b0, region_length_i} - 33'd1;
  assign end_blk = end_sum >> BB;
  assign last_in = (end_blk > 33'(bmbt_pkg::TBL_SIZE - 1)) ? bmbt_pkg::IDX_LAST
                                                          : IW'(end_blk);

  assign off      = addr_q[BB-1:0];
  assign need_end = {1'b0, off} + (LW'(1) << size_q);
  assign perm_ok  = (op_q == bmbt_pkg::OP_READ) ? rdata.prot[0] : rdata.prot[1];

  always_comb begin
    state_d  = state_q;
    blk_d    = blk_q;
    first_d  = first_q;
    last_d   = last_q;
    addr_d   = addr_q;
    op_d     = op_q;
    size_d   = size_q;
    rem_d    = rem_q;
    base_d   = base_q;
    prot_d   = prot_q;
    done_d   = 1'b0;
    status_d = status_q;
    target_d = target_q;
    raddr    = blk_q;
    wr       = '0;

    case (state_q)
      bmbt_pkg::ST_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = blk_q;
        if (blk_q == bmbt_pkg::IDX_LAST) begin
          state_d = bmbt_pkg::ST_IDLE;
        end else begin
          blk_d = blk_q + IW'(1);
        end
      end

      bmbt_pkg::ST_IDLE: begin
        raddr = IW'(addr_in >> BB) & bmbt_pkg::IDX_MASK;
        if (accept) begin
          addr_d  = addr_in;
          op_d    = operation_i;
          size_d  = size_code_i;
          rem_d   = region_length_i;
          base_d  = region_base_i;
          prot_d  = region_prot_i;
          first_d = IW'(addr_in >> BB) & bmbt_pkg::IDX_MASK;
          last_d  = last_in & bmbt_pkg::IDX_MASK;
          blk_d   = IW'(addr_in >> BB) & bmbt_pkg::IDX_MASK;
          case (operation_i)
            bmbt_pkg::OP_READ, bmbt_pkg::OP_WRITE: begin
              state_d = bmbt_pkg::ST_ACCESS;
            end
            bmbt_pkg::OP_MAP: begin
              if (region_length_i == 32'd0) begin
                done_d   = 1'b1;
                status_d = bmbt_pkg::STATUS_OK;
                target_d = 32'd0;
              end else begin
                state_d = bmbt_pkg::ST_SCAN_RD;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = bmbt_pkg::STATUS_DENIED;
              target_d = 32'd0;
            end
          endcase
        end
      end

      bmbt_pkg::ST_ACCESS: begin
        done_d   = 1'b1;
        target_d = 32'd0;
        state_d  = bmbt_pkg::ST_IDLE;
        if (!rdata.valid) begin
          status_d = bmbt_pkg::STATUS_UNMAPPED;
        end else if (!perm_ok) begin
          status_d = bmbt_pkg::STATUS_DENIED;
        end else if (need_end > rdata.length) begin
          status_d = bmbt_pkg::STATUS_BEYOND;
        end else begin
          status_d = bmbt_pkg::STATUS_OK;
          target_d = rdata.base + 32'(off);
        end
      end

      bmbt_pkg::ST_SCAN_RD: begin
        state_d = bmbt_pkg::ST_SCAN_CHK;
      end

      bmbt_pkg::ST_SCAN_CHK: begin
        if (rdata.valid) begin
          // abort the map, leave the table untouched
          done_d   = 1'b1;
          status_d = bmbt_pkg::STATUS_ALREADY;
          target_d = 32'd0;
          state_d  = bmbt_pkg::ST_IDLE;
        end else if (blk_q == last_q) begin
          blk_d   = first_q;
          state_d = bmbt_pkg::ST_WRITE;
        end else begin
          blk_d   = blk_q + IW'(1);
          state_d = bmbt_pkg::ST_SCAN_RD;
        end
      end

      bmbt_pkg::ST_WRITE: begin
        wr.we          = 1'b1;
        wr.addr        = blk_q;
        wr.data.valid  = 1'b1;
        wr.data.prot   = prot_q;
        wr.data.length = (rem_q > bmbt_pkg::BLK_SIZE) ? LW'(bmbt_pkg::BLK_SIZE)
                                                      : rem_q[LW-1:0];
        wr.data.base   = base_q;
        // advance to the next block, saturate the remaining length at zero
        rem_d  = (rem_q > bmbt_pkg::BLK_SIZE) ? (rem_q - bmbt_pkg::BLK_SIZE) : 32'd0;
        base_d = base_q + bmbt_pkg::BLK_SIZE;
        if (blk_q == last_q) begin
          done_d   = 1'b1;
          status_d = bmbt_pkg::STATUS_OK;
          target_d = 32'd0;
          state_d  = bmbt_pkg::ST_IDLE;
        end else begin
          blk_d = blk_q + IW'(1);
        end
      end

      default: begin
        state_d = bmbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmbt_pkg::ST_CLEAR;
      blk_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    addr_q   <= addr_d;
    op_q     <= op_d;
    size_q   <= size_d;
    rem_q    <= rem_d;
    base_q   <= base_d;
    prot_q   <= prot_d;
    status_q <= status_d;
    target_q <= target_d;
  end

  assign busy_o           = (state_q != bmbt_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign target_address_o = target_q;

  a_target_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != bmbt_pkg::STATUS_OK) |-> target_address_o == 32'd0)
    else $error("failed request carries a nonzero target address");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == bmbt_pkg::ST_CLEAR) || (state_q == bmbt_pkg::ST_WRITE))
    else $error("table written outside clear or fill");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bmbt_pkg::ST_WRITE |-> (blk_q >= first_q) && (blk_q <= last_q))
    else $error("fill block outside region");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == bmbt_pkg::ST_CLEAR) && (state_q != bmbt_pkg::ST_CLEAR)
    |-> $past(blk_q) == bmbt_pkg::IDX_LAST)
    else $error("clearing pass ended early");

  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bmbt_pkg::ST_CLEAR |-> !done_o)
    else $error("result strobe during clearing pass");

endmodule
